@@ hw/rtl/crg_pkg.sv @@
// Package with shared types, constants and helper functions of the camera ray generator.
package crg_pkg;

	localparam int unsigned ADDR_W = 6;
	localparam logic [2:0] REG_POS = 3'd0;
	localparam logic [2:0] REG_LOOK = 3'd1;
	localparam logic [2:0] REG_UP = 3'd2;
	localparam logic [2:0] REG_LEN = 3'd3;
	localparam logic [2:0] REG_SIZE = 3'd4;
	localparam logic [2:0] REG_ASP = 3'd5;

	localparam logic [62:0] POS_RESET = 63'd4376571674624;
	localparam logic [62:0] UP_RESET = 63'd4503599627370496;

	localparam logic signed [23:0] SAT_MAX = 24'sh7FFFFF;
	localparam logic signed [23:0] SAT_MIN = -24'sh800000;

	typedef logic signed [23:0] s24_t;

	typedef struct packed {
		s24_t [2:0] u;
		s24_t [2:0] v;
		s24_t [2:0] c;
		logic       degen;
	} basis_t;

	function automatic s24_t sat24(input logic signed [63:0] v);
		if (v > 64'sd8388607) begin
			return SAT_MAX;
		end else if (v < -64'sd8388608) begin
			return SAT_MIN;
		end
		return v[23:0];
	endfunction

	function automatic logic signed [20:0] comp21(input logic [62:0] p, input int idx);
		return p[21*idx +: 21];
	endfunction

endpackage

@@ hw/rtl/crg_basis.sv @@
// Multi-cycle sequencer that rebuilds the camera basis from the configuration registers.
module crg_basis (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 go,
	input  logic [62:0]          pos,
	input  logic [62:0]          look,
	input  logic [62:0]          up,
	input  logic [19:0]          len,
	input  logic [19:0]          hsize,
	input  logic [19:0]          asp,
	output logic                 done,
	output crg_pkg::basis_t      basis
);
	import crg_pkg::*;

	// Sequencer states.
	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_DIFF = 4'd1;
	localparam logic [3:0] ST_NSHIFT = 4'd2;
	localparam logic [3:0] ST_NSQ = 4'd3;
	localparam logic [3:0] ST_NSQRT = 4'd4;
	localparam logic [3:0] ST_NDIV = 4'd5;
	localparam logic [3:0] ST_CROSS1 = 4'd6;
	localparam logic [3:0] ST_CROSS2 = 4'd7;
	localparam logic [3:0] ST_FIN = 4'd8;
	localparam logic [3:0] ST_FDIV = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;

	logic [3:0]                state_q;
	logic [1:0]                pass_q;
	logic [1:0]                idx_q;
	logic signed [63:0]        vec_q [3];
	logic signed [31:0]        cmp_q [3];
	logic signed [15:0]        f_q [3];
	logic signed [15:0]        u_q [3];
	logic signed [15:0]        v_q [3];
	logic signed [15:0]        res_q [3];
	logic [63:0]               sum_q;
	logic [63:0]               rem_q;
	logic [31:0]               root_q;
	logic [5:0]                cnt_q;
	logic                      ok_q;
	logic signed [63:0]        mac_q;
	logic                      xterm_q;
	// Shared divider: |num| / den with rounding.
	logic [63:0]               dnum_q;
	logic [63:0]               dden_q;
	logic [63:0]               dquo_q;
	logic [63:0]               drem_q;
	logic [6:0]                dcnt_q;
	logic                      dneg_q;
	logic [1:0]                dsel_q;

	logic [63:0]               mag [3];
	logic [63:0]               mx;
	logic [5:0]                shamt;
	logic [63:0]               dtrial;

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			mag[i] = vec_q[i][63] ? 64'(-vec_q[i]) : 64'(vec_q[i]);
		end
		mx = mag[0];
		if (mag[1] > mx) begin
			mx = mag[1];
		end
		if (mag[2] > mx) begin
			mx = mag[2];
		end
		shamt = '0;
		for (int k = 0; k < 34; k++) begin
			if ((mx >> k) >= 64'd1073741824) begin
				shamt = 6'(k + 1);
			end
		end
		dtrial = {drem_q[62:0], dnum_q[63]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (go) begin
						state_q <= ST_DIFF;
					end
				end
				ST_DIFF: begin
					for (int i = 0; i < 3; i++) begin
						vec_q[i] <= 64'(comp21(look, i)) - 64'(comp21(pos, i));
					end
					pass_q <= 2'd0;
					ok_q <= 1'b1;
					state_q <= ST_NSHIFT;
				end
				ST_NSHIFT: begin
					for (int i = 0; i < 3; i++) begin
						cmp_q[i] <= vec_q[i][63] ? -32'(mag[i] >> shamt)
							: 32'(mag[i] >> shamt);
					end
					idx_q <= 2'd0;
					sum_q <= '0;
					state_q <= ST_NSQ;
				end
				ST_NSQ: begin
					sum_q <= sum_q + 64'(cmp_q[idx_q] * cmp_q[idx_q]);
					if (idx_q == 2'd2) begin
						cnt_q <= 6'd31;
						root_q <= '0;
						state_q <= ST_NSQRT;
					end else begin
						idx_q <= idx_q + 2'd1;
					end
				end
				ST_NSQRT: begin
					// One result bit per cycle, restoring square root.
					begin
						logic [63:0] rr;
						logic [63:0] tb;
						logic [63:0] rm;
						rm = (cnt_q == 6'd31) ? sum_q : rem_q;
						tb = 64'd1 << {cnt_q[4:0], 1'b0};
						rr = (64'(root_q) << (cnt_q[4:0] + 5'd1)) + tb;
						if (rm >= rr) begin
							rem_q <= rm - rr;
							root_q <= root_q | (32'd1 << cnt_q[4:0]);
						end else begin
							rem_q <= rm;
						end
					end
					if (cnt_q == 6'd0) begin
						idx_q <= 2'd0;
						state_q <= ST_NDIV;
						dcnt_q <= 7'd0;
					end else begin
						cnt_q <= cnt_q - 6'd1;
					end
				end
				ST_NDIV: begin
					if (root_q == 32'd0) begin
						for (int i = 0; i < 3; i++) begin
							res_q[i] <= '0;
						end
						ok_q <= 1'b0;
						state_q <= ST_CROSS1;
					end else if (dcnt_q == 7'd0) begin
						dnum_q <= (cmp_q[idx_q][31] ? 64'(-cmp_q[idx_q]) : 64'(cmp_q[idx_q]))
							* 64'd16384 + 64'(root_q >> 1);
						dneg_q <= cmp_q[idx_q][31];
						dden_q <= 64'(root_q);
						drem_q <= '0;
						dquo_q <= '0;
						dcnt_q <= 7'd1;
					end else if (dcnt_q <= 7'd64) begin
						if (dtrial >= dden_q) begin
							drem_q <= dtrial - dden_q;
							dquo_q <= {dquo_q[62:0], 1'b1};
						end else begin
							drem_q <= dtrial;
							dquo_q <= {dquo_q[62:0], 1'b0};
						end
						dnum_q <= {dnum_q[62:0], 1'b0};
						dcnt_q <= dcnt_q + 7'd1;
					end else begin
						res_q[idx_q] <= dneg_q ? -16'(dquo_q) : 16'(dquo_q);
						dcnt_q <= 7'd0;
						if (idx_q == 2'd2) begin
							state_q <= ST_CROSS1;
						end else begin
							idx_q <= idx_q + 2'd1;
						end
					end
				end
				ST_CROSS1: begin
					case (pass_q)
						2'd0: begin
							for (int i = 0; i < 3; i++) begin
								f_q[i] <= res_q[i];
							end
						end
						2'd1: begin
							for (int i = 0; i < 3; i++) begin
								u_q[i] <= res_q[i];
							end
						end
						default: begin
							for (int i = 0; i < 3; i++) begin
								v_q[i] <= res_q[i];
							end
						end
					endcase
					idx_q <= 2'd0;
					xterm_q <= 1'b0;
					state_q <= (pass_q == 2'd2) ? ST_FIN : ST_CROSS2;
				end
				ST_CROSS2: begin
					// Cross product, one product per cycle.
					begin
						logic signed [63:0] a1;
						logic signed [63:0] a2;
						logic signed [63:0] b1;
						logic signed [63:0] b2;
						logic [1:0] j1;
						logic [1:0] j2;
						j1 = (idx_q == 2'd2) ? 2'd0 : idx_q + 2'd1;
						j2 = (j1 == 2'd2) ? 2'd0 : j1 + 2'd1;
						if (pass_q == 2'd0) begin
							a1 = 64'(f_q[j1]);
							a2 = 64'(f_q[j2]);
							b1 = 64'(comp21(up, j1));
							b2 = 64'(comp21(up, j2));
						end else begin
							a1 = 64'(u_q[j1]);
							a2 = 64'(u_q[j2]);
							b1 = 64'(f_q[j1]);
							b2 = 64'(f_q[j2]);
						end
						if (!xterm_q) begin
							mac_q <= a1 * b2;
							xterm_q <= 1'b1;
						end else begin
							vec_q[idx_q] <= mac_q - a2 * b1;
							xterm_q <= 1'b0;
							if (idx_q == 2'd2) begin
								pass_q <= pass_q + 2'd1;
								state_q <= ST_NSHIFT;
							end else begin
								idx_q <= idx_q + 2'd1;
							end
						end
					end
				end
				ST_FIN: begin
					// Centre and U need no division by a signal; V goes to the divider.
					basis.c[idx_q] <= sat24(64'(comp21(pos, idx_q))
						+ ((64'($signed({1'b0, len})) * 64'(f_q[idx_q]) < 0)
						? -64'((64'(-(64'($signed({1'b0, len})) * 64'(f_q[idx_q])))
						+ 64'd8192) >> 14)
						: 64'((64'($signed({1'b0, len})) * 64'(f_q[idx_q]) + 64'd8192) >> 14)));
					begin
						logic signed [63:0] pu;
						pu = 64'(u_q[idx_q]) * 64'($signed({1'b0, hsize}));
						basis.u[idx_q] <= sat24(pu < 0 ? -64'((64'(-pu) + 64'd8192) >> 14)
							: 64'((pu + 64'd8192) >> 14));
					end
					begin
						logic signed [63:0] pv;
						logic [63:0] dd;
						pv = 64'(v_q[idx_q]) * 64'($signed({1'b0, hsize}));
						dd = 64'((asp == 20'd0) ? 20'd1 : asp) << 4;
						dnum_q <= (pv < 0 ? 64'(-pv) : 64'(pv)) + (dd >> 1);
						dneg_q <= pv < 0;
						dden_q <= dd;
					end
					drem_q <= '0;
					dquo_q <= '0;
					dcnt_q <= 7'd1;
					dsel_q <= idx_q;
					state_q <= ST_FDIV;
				end
				ST_FDIV: begin
					if (dcnt_q <= 7'd64) begin
						if (dtrial >= dden_q) begin
							drem_q <= dtrial - dden_q;
							dquo_q <= {dquo_q[62:0], 1'b1};
						end else begin
							drem_q <= dtrial;
							dquo_q <= {dquo_q[62:0], 1'b0};
						end
						dnum_q <= {dnum_q[62:0], 1'b0};
						dcnt_q <= dcnt_q + 7'd1;
					end else begin
						basis.v[dsel_q] <= sat24(dneg_q ? -$signed(dquo_q) : $signed(dquo_q));
						if (idx_q == 2'd2) begin
							basis.degen <= !ok_q;
							state_q <= ST_DONE;
						end else begin
							idx_q <= idx_q + 2'd1;
							state_q <= ST_FIN;
						end
					end
				end
				ST_DONE: begin
					done <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ hw/rtl/camera_ray_generator.sv @@
// Top level of the pinhole camera ray generator: registers, basis sequencer and ray pipeline.
// Rays flow through a four-stage pipeline, registered in v_s1 to v_s4, at one transaction
// per cycle while busy is low; result_valid marks each result for one cycle and cannot be
// held off. After any register write, start is ignored while the basis sequencer rebuilds
// the basis with its bit-serial square root and divider; busy is high during that time.
module camera_ray_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic signed [15:0]          screen_x,
	input  logic signed [15:0]          screen_y,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [crg_pkg::ADDR_W-1:0]  paddr,
	input  logic [63:0]                 pwdata,
	output logic [63:0]                 prdata,
	output logic                        pready,
	output logic                        result_valid,
	output logic signed [23:0]          origin_x,
	output logic signed [23:0]          origin_y,
	output logic signed [23:0]          origin_z,
	output logic signed [23:0]          screen_point_x,
	output logic signed [23:0]          screen_point_y,
	output logic signed [23:0]          screen_point_z,
	output logic signed [23:0]          dir_x,
	output logic signed [23:0]          dir_y,
	output logic signed [23:0]          dir_z,
	output logic                        degenerate
);
	import crg_pkg::*;

	logic [62:0] pos_q, look_q, up_q;
	logic [19:0] len_q, size_q, asp_q;
	logic        stale_q;
	logic        run_q;
	logic        done;
	basis_t      basis;
	logic        wr;
	logic [2:0]  widx;

	assign pready = 1'b1;
	assign wr = psel && penable && pwrite;
	assign widx = paddr[5:3];
	assign busy = stale_q || run_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= POS_RESET;
			look_q <= '0;
			up_q <= UP_RESET;
			len_q <= 20'd1024;
			size_q <= 20'd1024;
			asp_q <= 20'd1024;
			stale_q <= 1'b1;
			run_q <= 1'b0;
		end else begin
			if (wr) begin
				case (widx)
					REG_POS: pos_q <= pwdata[62:0];
					REG_LOOK: look_q <= pwdata[62:0];
					REG_UP: up_q <= pwdata[62:0];
					REG_LEN: len_q <= pwdata[19:0];
					REG_SIZE: size_q <= pwdata[19:0];
					REG_ASP: asp_q <= pwdata[19:0];
					default: ;
				endcase
				if (widx <= REG_ASP) begin
					stale_q <= 1'b1;
				end
			end
			if (done) begin
				run_q <= 1'b0;
			end else if (stale_q && !run_q && !wr) begin
				run_q <= 1'b1;
				stale_q <= 1'b0;
			end
		end
	end

	always_comb begin
		case (widx)
			REG_POS: prdata = {1'b0, pos_q};
			REG_LOOK: prdata = {1'b0, look_q};
			REG_UP: prdata = {1'b0, up_q};
			REG_LEN: prdata = {44'd0, len_q};
			REG_SIZE: prdata = {44'd0, size_q};
			REG_ASP: prdata = {44'd0, asp_q};
			default: prdata = '0;
		endcase
	end

	crg_basis u_basis (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (stale_q && !run_q && !wr),
		.pos    (pos_q),
		.look   (look_q),
		.up     (up_q),
		.len    (len_q),
		.hsize  (size_q),
		.asp    (asp_q),
		.done   (done),
		.basis  (basis)
	);

	// Ray pipeline.
	logic               v_s1, v_s2, v_s3, v_s4;
	logic signed [39:0] pu_s1 [3], pv_s1 [3];
	logic signed [39:0] pc_s1 [3];
	logic signed [41:0] acc_s2 [3];
	logic signed [31:0] p_s3 [3];
	logic signed [20:0] pos_s1 [3], pos_s2 [3], pos_s3 [3];
	logic               dg_s1, dg_s2, dg_s3;
	s24_t               o_s4 [3], sp_s4 [3], d_s4 [3];
	logic               dg_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < 3; i++) begin
			pu_s1[i] <= 40'(basis.u[i]) * 40'(screen_x);
			pv_s1[i] <= 40'(basis.v[i]) * 40'(screen_y);
			pc_s1[i] <= 40'(basis.c[i]) <<< 14;
			pos_s1[i] <= comp21(pos_q, i);
			acc_s2[i] <= 42'(pu_s1[i]) + 42'(pv_s1[i]) + 42'(pc_s1[i]);
			pos_s2[i] <= pos_s1[i];
			p_s3[i] <= acc_s2[i][41] ? -32'((42'(-acc_s2[i]) + 42'd8192) >>> 14)
				: 32'((acc_s2[i] + 42'd8192) >>> 14);
			pos_s3[i] <= pos_s2[i];
			o_s4[i] <= 24'(pos_s3[i]);
			sp_s4[i] <= sat24(64'(p_s3[i]));
			d_s4[i] <= sat24(64'(p_s3[i]) - 64'(pos_s3[i]));
		end
		dg_s1 <= basis.degen;
		dg_s2 <= dg_s1;
		dg_s3 <= dg_s2;
		dg_s4 <= dg_s3;
	end

	assign result_valid = v_s4;
	assign origin_x = o_s4[0];
	assign origin_y = o_s4[1];
	assign origin_z = o_s4[2];
	assign screen_point_x = sp_s4[0];
	assign screen_point_y = sp_s4[1];
	assign screen_point_z = sp_s4[2];
	assign dir_x = d_s4[0];
	assign dir_y = d_s4[1];
	assign dir_z = d_s4[2];
	assign degenerate = dg_s4;

endmodule
